### rtl/ttnf_pkg.sv
// ----------------------------------------------------------------------------
// ttnf_pkg
// Shared types, constants and format helpers for the texel neighbor fill.
// ----------------------------------------------------------------------------
`default_nettype none

package ttnf_pkg;

  typedef enum logic [1:0] {
    FMT_ARGB8888 = 2'd0,
    FMT_ARGB1555 = 2'd1,
    FMT_ARGB4444 = 2'd2,
    FMT_ARGB8332 = 2'd3
  } fmt_e;

  localparam int unsigned PIX_W  = 32;
  localparam int unsigned NUM_NB = 4;   // left, right, upper, lower
  localparam int unsigned NUM_CH = 3;   // red, green, blue
  localparam int unsigned CH_W   = 8;
  localparam int unsigned SUM_W  = 10;  // four 8-bit channels
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned PROD_W = 2 * SUM_W;

  // floor(x / 3) == (x * 683) >> 11 for every x below 1024
  localparam logic [SUM_W-1:0] RECIP3       = 10'd683;
  localparam int unsigned      RECIP3_SHIFT = 11;

  localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  chan_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_t;

  // Stage 1 -> stage 2: decoded neighbors, channels zeroed where not used
  typedef struct packed {
    fmt_e                     fmt;
    logic                     center_opaque;
    logic [PIX_W-1:0]         center;
    logic [NUM_NB-1:0]        contrib;
    logic [NUM_NB-1:0][NUM_CH-1:0][CH_W-1:0] chan;
  } unpack_t;

  // Stage 2 -> stage 3: per-channel sums and contributor count
  typedef struct packed {
    fmt_e             fmt;
    logic             center_opaque;
    logic [PIX_W-1:0] center;
    logic [CNT_W-1:0] cnt;
    sum_t             sum;
  } accum_t;

  // Stage 3 -> output stage: averaged channels
  typedef struct packed {
    fmt_e             fmt;
    logic             center_opaque;
    logic [PIX_W-1:0] center;
    logic [CNT_W-1:0] cnt;
    chan_t            avg;
  } avg_t;

  function automatic logic [PIX_W-1:0] alpha_mask(input fmt_e fmt);
    case (fmt)
      FMT_ARGB8888: alpha_mask = 32'hff00_0000;
      FMT_ARGB1555: alpha_mask = 32'h0000_8000;
      FMT_ARGB4444: alpha_mask = 32'h0000_f000;
      default:      alpha_mask = 32'h0000_ff00;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] word_mask(input fmt_e fmt);
    word_mask = (fmt == FMT_ARGB8888) ? 32'hffff_ffff : 32'h0000_ffff;
  endfunction

  function automatic logic [4:0] ch_shift(input fmt_e fmt, input logic [1:0] ch);
    logic [4:0] s;
    s = 5'd0;
    case (fmt)
      FMT_ARGB8888: s = (ch == 2'd0) ? 5'd16 : (ch == 2'd1) ? 5'd8 : 5'd0;
      FMT_ARGB1555: s = (ch == 2'd0) ? 5'd10 : (ch == 2'd1) ? 5'd5 : 5'd0;
      FMT_ARGB4444: s = (ch == 2'd0) ? 5'd8  : (ch == 2'd1) ? 5'd4 : 5'd0;
      default:      s = (ch == 2'd0) ? 5'd5  : (ch == 2'd1) ? 5'd2 : 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [CH_W-1:0] ch_mask(input fmt_e fmt, input logic [1:0] ch);
    logic [CH_W-1:0] m;
    m = 8'd0;
    case (fmt)
      FMT_ARGB8888: m = 8'd255;
      FMT_ARGB1555: m = 8'd31;
      FMT_ARGB4444: m = 8'd15;
      default:      m = (ch == 2'd2) ? 8'd3 : 8'd7;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/ttnf_unpack.sv
// ----------------------------------------------------------------------------
// ttnf_unpack
// Stage 1: mask texels to the format, test opacity, extract RGB channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ttnf_unpack (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  input  wire ttnf_pkg::fmt_e                            fmt_i,
  input  wire logic [ttnf_pkg::PIX_W-1:0]                center_i,
  input  wire logic [ttnf_pkg::NUM_NB-1:0][ttnf_pkg::PIX_W-1:0] nb_i,
  input  wire logic [ttnf_pkg::NUM_NB-1:0]               has_i,
  output logic                                           valid_o,
  output ttnf_pkg::unpack_t                              data_o
);

  import ttnf_pkg::*;

  logic    valid_q;
  unpack_t data_d, data_q;
  logic [NUM_NB-1:0][PIX_W-1:0] nb_word;
  logic [PIX_W-1:0]             center_word;

  always_comb begin
    center_word = center_i & word_mask(fmt_i);
    data_d = '0;
    data_d.fmt           = fmt_i;
    data_d.center        = center_word;
    data_d.center_opaque = |(center_word & alpha_mask(fmt_i));
    for (int n = 0; n < NUM_NB; n++) begin
      nb_word[n]        = nb_i[n] & word_mask(fmt_i);
      data_d.contrib[n] = has_i[n] && (|(nb_word[n] & alpha_mask(fmt_i)));
      for (int c = 0; c < NUM_CH; c++) begin
        // drop channels of absent or transparent neighbors
        data_d.chan[n][c] = data_d.contrib[n]
                          ? CH_W'(nb_word[n] >> ch_shift(fmt_i, 2'(c))) & ch_mask(fmt_i, 2'(c))
                          : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/ttnf_accum.sv
// ----------------------------------------------------------------------------
// ttnf_accum
// Stage 2: sum channels over contributing neighbors and count them.
// ----------------------------------------------------------------------------
`default_nettype none

module ttnf_accum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire ttnf_pkg::unpack_t data_i,
  output logic                   valid_o,
  output ttnf_pkg::accum_t       data_o
);

  import ttnf_pkg::*;

  logic   valid_q;
  accum_t data_d, data_q;

  always_comb begin
    data_d.fmt           = data_i.fmt;
    data_d.center_opaque = data_i.center_opaque;
    data_d.center        = data_i.center;
    data_d.cnt           = CNT_W'($countones(data_i.contrib));
    for (int c = 0; c < NUM_CH; c++) begin
      data_d.sum[c] = SUM_W'(data_i.chan[0][c]) + SUM_W'(data_i.chan[1][c])
                    + SUM_W'(data_i.chan[2][c]) + SUM_W'(data_i.chan[3][c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/ttnf_divide.sv
// ----------------------------------------------------------------------------
// ttnf_divide
// Stage 3: divide channel sums by the contributor count (0 to 4).
// ----------------------------------------------------------------------------
`default_nettype none

module ttnf_divide (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire ttnf_pkg::accum_t data_i,
  output logic                  valid_o,
  output ttnf_pkg::avg_t        data_o
);

  import ttnf_pkg::*;

  logic  valid_q;
  avg_t  data_d, data_q;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  logic [NUM_CH-1:0][SUM_W-1:0]  quot;

  always_comb begin
    data_d.fmt           = data_i.fmt;
    data_d.center_opaque = data_i.center_opaque;
    data_d.center        = data_i.center;
    data_d.cnt           = data_i.cnt;
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(data_i.sum[c]) * PROD_W'(RECIP3);
      case (data_i.cnt)
        CNT_TWO:   quot[c] = data_i.sum[c] >> 1;
        CNT_THREE: quot[c] = SUM_W'(prod[c] >> RECIP3_SHIFT);
        CNT_FOUR:  quot[c] = data_i.sum[c] >> 2;
        default:   quot[c] = data_i.sum[c];
      endcase
      data_d.avg[c] = CH_W'(quot[c]) & ch_mask(data_i.fmt, 2'(c));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/transparent_texel_neighbor_fill.sv
// ----------------------------------------------------------------------------
// transparent_texel_neighbor_fill
// Fill the color of a transparent texel from its opaque four-neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the center texel, its four neighbors and their
//   presence flags together with start_i; a transaction is taken at every
//   rising edge where start_i is high and busy_o is low. busy_o never rises,
//   so one texel may be issued every clock.
//   Result channel: done_o pulses for one cycle with repaired_pixel_o,
//   was_transparent_o and opaque_neighbor_count_o. The receiver cannot stall
//   it and must take each result in that cycle.
//   The result is registered through the four-stage pipeline (unpack,
//   accumulate, divide, pack), each stage holding one item; throughput is
//   one texel per clock.
//   Configuration: pixel_format is written through cfg_valid_i/cfg_ready_o
//   with cfg_data_i; cfg_ready_o is always high. Write it only while the
//   pipeline is empty; each stage carries its own copy of the format.
//   Reset clears every stage valid bit and sets the format to ARGB8888.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_texel_neighbor_fill (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input transactions
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ttnf_pkg::PIX_W-1:0]    center_pixel_i,
  input  wire logic [ttnf_pkg::PIX_W-1:0]    left_pixel_i,
  input  wire logic [ttnf_pkg::PIX_W-1:0]    right_pixel_i,
  input  wire logic [ttnf_pkg::PIX_W-1:0]    upper_pixel_i,
  input  wire logic [ttnf_pkg::PIX_W-1:0]    lower_pixel_i,
  input  wire logic                          has_left_i,
  input  wire logic                          has_right_i,
  input  wire logic                          has_upper_i,
  input  wire logic                          has_lower_i,
  // result transactions
  output logic                               done_o,
  output logic [ttnf_pkg::PIX_W-1:0]         repaired_pixel_o,
  output logic                               was_transparent_o,
  output logic [ttnf_pkg::CNT_W-1:0]         opaque_neighbor_count_o,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_data_i
);

  import ttnf_pkg::*;

  // Format register
  fmt_e fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_ARGB8888;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= fmt_e'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;
  // Pipeline never stalls: accept every cycle
  assign busy_o      = 1'b0;

  logic in_fire;
  assign in_fire = start_i && !busy_o;

  // Stage 1: unpack
  logic    s1_valid;
  unpack_t s1_data;

  ttnf_unpack u_unpack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_fire),
    .fmt_i    (fmt_q),
    .center_i (center_pixel_i),
    .nb_i     ({lower_pixel_i, upper_pixel_i, right_pixel_i, left_pixel_i}),
    .has_i    ({has_lower_i, has_upper_i, has_right_i, has_left_i}),
    .valid_o  (s1_valid),
    .data_o   (s1_data)
  );

  // Stage 2: accumulate
  logic   s2_valid;
  accum_t s2_data;

  ttnf_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  // Stage 3: divide by count
  logic s3_valid;
  avg_t s3_data;

  ttnf_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .data_o  (s3_data)
  );

  // Stage 4: repack channels into the texel word and register the result
  logic             out_valid_q;
  fmt_e             out_fmt_q;
  logic [PIX_W-1:0] pixel_d, pixel_q;
  logic             transp_d, transp_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  always_comb begin
    if (s3_data.center_opaque) begin
      // pass an opaque center through unchanged
      pixel_d  = s3_data.center;
      transp_d = 1'b0;
      cnt_d    = '0;
    end else begin
      // keep the center alpha, replace the color
      pixel_d = s3_data.center & alpha_mask(s3_data.fmt);
      for (int c = 0; c < NUM_CH; c++) begin
        pixel_d = pixel_d | (PIX_W'(s3_data.avg[c]) << ch_shift(s3_data.fmt, 2'(c)));
      end
      pixel_d  = pixel_d & word_mask(s3_data.fmt);
      transp_d = 1'b1;
      cnt_d    = s3_data.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid) begin
      pixel_q   <= pixel_d;
      transp_q  <= transp_d;
      cnt_q     <= cnt_d;
      out_fmt_q <= s3_data.fmt;
    end
  end

  assign done_o                  = out_valid_q;
  assign repaired_pixel_o        = pixel_q;
  assign was_transparent_o       = transp_q;
  assign opaque_neighbor_count_o = cnt_q;

`ifndef SYNTHESIS
  // Every accepted transaction comes out as a done_o result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##4 done_o)
    else $error("result missing four cycles after accept");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_fire, 4))
    else $error("result without a matching accepted transaction");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (opaque_neighbor_count_o <= CNT_W'(NUM_NB)) &&
               (was_transparent_o || opaque_neighbor_count_o == '0))
    else $error("neighbor count out of range or set for opaque center");

  a_no_neighbor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && was_transparent_o && opaque_neighbor_count_o == '0
      |-> repaired_pixel_o == '0)
    else $error("transparent texel without neighbors not cleared");

  a_narrow_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_fmt_q != FMT_ARGB8888 |-> repaired_pixel_o[31:16] == 16'h0)
    else $error("upper half set in a 16-bit format");
`endif

endmodule

`default_nettype wire

### tb/sv/transparent_texel_neighbor_fill_tb.sv
// ----------------------------------------------------------------------------
// transparent_texel_neighbor_fill_tb
// Self-checking bench for the four-neighbor fill of transparent texels.
// A queue of texel transactions feeds a driver that works in random bursts.
// A monitor predicts every accepted transaction at the accepting edge and
// compares each done_o pulse against the oldest prediction. The run walks
// through every pixel format, with a short directed set per format followed
// by random traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_texel_neighbor_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttnf_pkg::*;

  // Neighbor slots, in the order the ports list them
  localparam int NB_LEFT  = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_UPPER = 2;
  localparam int NB_LOWER = 3;

  localparam int NUM_PHASES     = 9;
  localparam int DIRECTED_PHASE = 4;    // phases that open with the directed set
  localparam int RAND_PER_PHASE = 190;
  localparam int STALL_LIMIT    = 2000; // cycles with no handshake of any kind
  localparam int TAIL_CYCLES    = 8;    // pipeline is four deep
  localparam int REPORT_MAX     = 10;

  typedef struct {
    logic [PIX_W-1:0]             center;
    logic [NUM_NB-1:0][PIX_W-1:0] nb;
    logic [NUM_NB-1:0]            present;
  } texel_req_t;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             transparent;
    logic [CNT_W-1:0] count;
  } fill_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [PIX_W-1:0] center_pixel_i;
  logic [PIX_W-1:0] left_pixel_i;
  logic [PIX_W-1:0] right_pixel_i;
  logic [PIX_W-1:0] upper_pixel_i;
  logic [PIX_W-1:0] lower_pixel_i;
  logic             has_left_i;
  logic             has_right_i;
  logic             has_upper_i;
  logic             has_lower_i;
  logic             done_o;
  logic [PIX_W-1:0] repaired_pixel_o;
  logic             was_transparent_o;
  logic [CNT_W-1:0] opaque_neighbor_count_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_data_i;

  texel_req_t   texel_backlog[$];    // transactions not yet offered
  fill_result_t predicted_fills[$];  // results owed by the pipeline
  fmt_e         model_fmt = FMT_ARGB8888;
  logic         req_taken;
  int           errors     = 0;
  int           idle_run   = 0;
  int           burst_left = 0;
  int           gap_left   = 0;

  transparent_texel_neighbor_fill uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .start_i                 (start_i),
    .busy_o                  (busy_o),
    .center_pixel_i          (center_pixel_i),
    .left_pixel_i            (left_pixel_i),
    .right_pixel_i           (right_pixel_i),
    .upper_pixel_i           (upper_pixel_i),
    .lower_pixel_i           (lower_pixel_i),
    .has_left_i              (has_left_i),
    .has_right_i             (has_right_i),
    .has_upper_i             (has_upper_i),
    .has_lower_i             (has_lower_i),
    .done_o                  (done_o),
    .repaired_pixel_o        (repaired_pixel_o),
    .was_transparent_o       (was_transparent_o),
    .opaque_neighbor_count_o (opaque_neighbor_count_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_data_i              (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Alpha bits of a texel; a texel is opaque when any of them is set.
  function automatic logic [PIX_W-1:0] fmt_alpha(input fmt_e fmt);
    case (fmt)
      FMT_ARGB8888: return 32'hff00_0000;
      FMT_ARGB1555: return 32'h0000_8000;
      FMT_ARGB4444: return 32'h0000_f000;
      default:      return 32'h0000_ff00;
    endcase
  endfunction

  // Expected result for one texel transaction under the given format.
  function automatic fill_result_t bleed_predict(input fmt_e fmt, input texel_req_t t);
    logic [PIX_W-1:0] am;
    logic [PIX_W-1:0] wm;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] nb;
    logic [PIX_W-1:0] acc;
    int unsigned      shf [3];
    int unsigned      lim [3];
    int unsigned      tot [3];
    int unsigned      n;
    int unsigned      v;
    fill_result_t     r;
    am = fmt_alpha(fmt);
    // 16-bit formats ignore the upper half of every texel
    wm = (fmt == FMT_ARGB8888) ? 32'hffff_ffff : 32'h0000_ffff;
    case (fmt)
      FMT_ARGB8888: begin
        shf = '{16, 8, 0};
        lim = '{255, 255, 255};
      end
      FMT_ARGB1555: begin
        shf = '{10, 5, 0};
        lim = '{31, 31, 31};
      end
      FMT_ARGB4444: begin
        shf = '{8, 4, 0};
        lim = '{15, 15, 15};
      end
      default: begin
        shf = '{5, 2, 0};
        lim = '{7, 7, 3};
      end
    endcase
    ctr = t.center & wm;
    // Opaque center passes through untouched
    if ((ctr & am) != '0) begin
      r.pixel       = ctr;
      r.transparent = 1'b0;
      r.count       = '0;
      return r;
    end
    tot = '{0, 0, 0};
    n   = 0;
    for (int k = 0; k < NUM_NB; k++) begin
      nb = t.nb[k] & wm;
      if (t.present[k] && (nb & am) != '0) begin
        for (int c = 0; c < NUM_CH; c++) tot[c] += (nb >> shf[c]) & lim[c];
        n++;
      end
    end
    // Keep the center alpha, average the colors, truncating
    acc = ctr & am;
    for (int c = 0; c < NUM_CH; c++) begin
      v = tot[c];
      if (n > 1) v = v / n;
      acc |= (v & lim[c]) << shf[c];
    end
    r.pixel       = acc & wm;
    r.transparent = 1'b1;
    r.count       = 3'(n);
    return r;
  endfunction

  function automatic texel_req_t make_req(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] l,
                                          input logic [PIX_W-1:0] rt, input logic [PIX_W-1:0] u,
                                          input logic [PIX_W-1:0] d, input logic [3:0] p);
    texel_req_t t;
    t.center       = c;
    t.nb[NB_LEFT]  = l;
    t.nb[NB_RIGHT] = rt;
    t.nb[NB_UPPER] = u;
    t.nb[NB_LOWER] = d;
    t.present      = p;
    return t;
  endfunction

  // Random texel, either transparent or opaque, now and then with saturated colors.
  function automatic logic [PIX_W-1:0] random_texel(input logic [PIX_W-1:0] am,
                                                    input bit clear_alpha);
    logic [PIX_W-1:0] w;
    w = $urandom();
    if ($urandom_range(0, 7) == 0) w = 32'hffff_ffff;
    if (clear_alpha) w &= ~am;
    else if ((w & am) == '0) w |= am;
    return w;
  endfunction

  function automatic texel_req_t random_req(input fmt_e fmt);
    logic [PIX_W-1:0] am;
    texel_req_t       t;
    am       = fmt_alpha(fmt);
    // Bias toward transparent centers: that is where the averaging lives
    t.center = random_texel(am, $urandom_range(0, 9) < 7);
    for (int k = 0; k < NUM_NB; k++) begin
      t.nb[k]      = random_texel(am, $urandom_range(0, 9) < 4);
      t.present[k] = $urandom_range(0, 9) < 8;
    end
    return t;
  endfunction

  task automatic queue_directed(input fmt_e fmt);
    logic [PIX_W-1:0] am;
    am = fmt_alpha(fmt);
    // Opaque center passes through; 16-bit formats drop the upper half
    texel_backlog.push_back(make_req('1, '1, '1, '1, '1, 4'b1111));
    // Transparent center with every neighbor absent: color goes to zero
    texel_backlog.push_back(make_req(~am, '1, '1, '1, '1, 4'b0000));
    // Four saturated neighbors: largest sums, divide by four
    texel_backlog.push_back(make_req('0, '1, '1, '1, '1, 4'b1111));
    // Single opaque neighbor among transparent ones: plain copy
    texel_backlog.push_back(make_req(~am, ~am, ~am, ~am, $urandom() | am, 4'b1111));
    // Three opaque neighbors: divide by three
    texel_backlog.push_back(make_req('0, $urandom() | am, $urandom() | am, $urandom() | am,
                                     ~am, 4'b1111));
    // Two contributors, one black and one white; absent ones are opaque but skipped
    texel_backlog.push_back(make_req(~am, am, '1, '1, '1, 4'b0011));
  endtask

  // Wait until the pipeline is empty and nothing is owed.
  task automatic drain();
    while (texel_backlog.size() != 0 || start_i || predicted_fills.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_format(input fmt_e f);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_fmt = f;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: offer one transaction per cycle in bursts, hold it until taken,
  // and insert random gaps between bursts (zero-length gaps give back-to-back runs).
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !req_taken) begin
      // hold the current transaction
    end else if (gap_left != 0) begin
      gap_left = gap_left - 1;
      start_i <= 1'b0;
    end else if (texel_backlog.size() != 0) begin
      texel_req_t nxt;
      nxt = texel_backlog.pop_front();
      center_pixel_i <= nxt.center;
      left_pixel_i   <= nxt.nb[NB_LEFT];
      right_pixel_i  <= nxt.nb[NB_RIGHT];
      upper_pixel_i  <= nxt.nb[NB_UPPER];
      lower_pixel_i  <= nxt.nb[NB_LOWER];
      has_left_i     <= nxt.present[NB_LEFT];
      has_right_i    <= nxt.present[NB_RIGHT];
      has_upper_i    <= nxt.present[NB_UPPER];
      has_lower_i    <= nxt.present[NB_LOWER];
      start_i        <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: check the result leaving the pipeline against the oldest
  // prediction, then predict the transaction entering it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (predicted_fills.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result: pixel=%h wt=%b cnt=%0d",
                     repaired_pixel_o, was_transparent_o, opaque_neighbor_count_o);
        end else begin
          fill_result_t want;
          want = predicted_fills.pop_front();
          if (repaired_pixel_o !== want.pixel || was_transparent_o !== want.transparent ||
              opaque_neighbor_count_o !== want.count) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("mismatch: exp pixel=%h wt=%b cnt=%0d, got pixel=%h wt=%b cnt=%0d",
                       want.pixel, want.transparent, want.count,
                       repaired_pixel_o, was_transparent_o, opaque_neighbor_count_o);
          end
        end
      end
      if (start_i && !busy_o)
        predicted_fills.push_back(bleed_predict(model_fmt,
          make_req(center_pixel_i, left_pixel_i, right_pixel_i, upper_pixel_i, lower_pixel_i,
                   {has_lower_i, has_upper_i, has_right_i, has_left_i})));
      req_taken <= start_i && !busy_o;
    end
  end

  // Watchdog: drop the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    fmt_e phase_fmt [NUM_PHASES];
    // Reset phase first, then every format, extremes revisited
    phase_fmt = '{FMT_ARGB8888, FMT_ARGB1555, FMT_ARGB4444, FMT_ARGB8332, FMT_ARGB8888,
                  FMT_ARGB8332, FMT_ARGB1555, FMT_ARGB4444, FMT_ARGB8888};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    center_pixel_i = '0;
    left_pixel_i   = '0;
    right_pixel_i  = '0;
    upper_pixel_i  = '0;
    lower_pixel_i  = '0;
    has_left_i     = 1'b0;
    has_right_i    = 1'b0;
    has_upper_i    = 1'b0;
    has_lower_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = FMT_ARGB8888;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Phase 0 runs on the reset format; later ones change it while idle
      if (p != 0) begin
        drain();
        write_format(phase_fmt[p]);
      end
      if (p < DIRECTED_PHASE) queue_directed(phase_fmt[p]);
      for (int i = 0; i < RAND_PER_PHASE; i++) texel_backlog.push_back(random_req(phase_fmt[p]));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    errors += predicted_fills.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
